// ===== rtl/char_class_histogram_candle_core_assert.svh =====
// Assertion macros for the character histogram candle core.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the expected consequence.
`ifndef CHAR_CLASS_HISTOGRAM_CANDLE_CORE_ASSERT_SVH
`define CHAR_CLASS_HISTOGRAM_CANDLE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequence must hold in the same cycle as the condition.
`define CCHC_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("cchc assertion failed");
// The consequence must hold in the cycle after the condition.
`define CCHC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("cchc assertion failed");
`else
`define CCHC_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define CCHC_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

// ===== rtl/cchc_pkg.sv =====
`default_nettype none

package cchc_pkg;

    // Request commands.
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_EOL  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Wide enough for every entry index at the largest alphabet.
    localparam int IDX_W       = 9;
    localparam int NUM_CLASSES = 9;

    // Class codes, in entry order after the character bins.
    localparam logic [3:0] CLS_DIGIT     = 4'd0;
    localparam logic [3:0] CLS_INT       = 4'd1;
    localparam logic [3:0] CLS_DECIMAL   = 4'd2;
    localparam logic [3:0] CLS_FLOAT     = 4'd3;
    localparam logic [3:0] CLS_INT_COPY  = 4'd4;
    localparam logic [3:0] CLS_HEX       = 4'd5;
    localparam logic [3:0] CLS_HSPACE    = 4'd6;
    localparam logic [3:0] CLS_VSPACE    = 4'd7;
    localparam logic [3:0] CLS_SPACE     = 4'd8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // One request as it travels down the cell chain. Read results are
    // filled in by the cell whose entry matches.
    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic [7:0] entry_index;
        logic       bumped;
        logic [7:0] live_count;
        logic [7:0] candle_open;
        logic [7:0] candle_high;
        logic [7:0] candle_low;
        logic [7:0] candle_close;
    } t_req;

    function automatic logic class_member(input logic [3:0] k, input logic [7:0] b);
        logic dig;
        logic hs;
        logic vs;
        logic res;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        hs  = (b == CH_SPACE) || (b == CH_BS) || (b == CH_CR) || (b == CH_TAB);
        vs  = (b == CH_FF) || (b == CH_LF) || (b == CH_VT);
        case (k)
            CLS_DIGIT:    res = dig;
            CLS_INT:      res = dig || (b == CH_MINUS);
            CLS_DECIMAL:  res = dig || (b == CH_MINUS) || (b == CH_DOT);
            CLS_FLOAT:    res = dig || (b == CH_E_LO) || (b == CH_E_UP) ||
                                (b == CH_PLUS) || (b == CH_MINUS) || (b == CH_DOT);
            CLS_INT_COPY: res = dig || (b == CH_MINUS);
            CLS_HEX:      res = dig || ((b >= CH_A_LO) && (b <= CH_F_LO)) ||
                                ((b >= CH_A_UP) && (b <= CH_F_UP));
            CLS_HSPACE:   res = hs;
            CLS_VSPACE:   res = vs;
            CLS_SPACE:    res = hs || vs;
            default:      res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cchc_ifs.sv =====
`default_nettype none

interface cchc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] entry_index;

    modport source(output valid, output cmd, output data_byte, output entry_index,
                   input ready);
    modport sink(input valid, input cmd, input data_byte, input entry_index,
                 output ready);
endinterface

interface cchc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] live_count;
    logic [7:0] candle_open;
    logic [7:0] candle_high;
    logic [7:0] candle_low;
    logic [7:0] candle_close;

    modport source(output valid, output live_count, output candle_open,
                   output candle_high, output candle_low, output candle_close,
                   input ready);
    modport sink(input valid, input live_count, input candle_open,
                 input candle_high, input candle_low, input candle_close,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/char_class_histogram_candle_core.sv =====
`default_nettype none

// Per-line character histogram with open/high/low/close candles. Each entry
// (ALPHABET_SIZE character bins, then nine character classes) lives in one
// cell of a linear chain, and every request walks down the chain one cell
// per cycle, so the block accepts a new request in every cycle unless the
// chain stalls. A read passes through the cells in order: the first cell
// takes it at the edge that accepts it, then each further cell in turn,
// and the output register takes the result after the last cell. A data
// byte raises the count of its bin and then of each class that holds it;
// an end-of-line request folds every entry into its candle and clears the
// live counts as it passes; a read request picks up the matching entry's
// values and is the only request that produces a result. A read of an index
// past the last class returns all zeros, and command code 3 is dropped.
// Reset clears every cell at once, so no clearing pass is needed. The chain
// stalls only when a read reaches its end while the output register still
// holds a result that has not been taken.
module char_class_histogram_candle_core #(
    parameter int ALPHABET_SIZE = 128,
    parameter int COUNTER_BITS  = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cchc_in_if.sink      i_req,
    cchc_out_if.source   o_res
);

    localparam int NumEntries = ALPHABET_SIZE + cchc_pkg::NUM_CLASSES;

    cchc_pkg::t_req w_chain [0:NumEntries];
    cchc_pkg::t_req w_head;
    cchc_pkg::t_req w_last;
    cchc_pkg::t_req r_out;
    logic           r_out_vld;
    logic           w_out_free;
    logic           w_last_read;
    logic           w_adv;

    // The head of the chain sees the incoming request directly; result
    // fields start at zero so that an unmatched read returns zeros.
    always_comb begin
        w_head              = '0;
        w_head.valid        = i_req.valid;
        w_head.cmd          = i_req.cmd;
        w_head.data_byte    = i_req.data_byte;
        w_head.entry_index  = i_req.entry_index;
    end

    assign w_chain[0] = w_head;

    generate
        for (genvar g = 0; g < NumEntries; g++) begin : g_cell
            cchc_cell #(
                .ALPHABET_SIZE (ALPHABET_SIZE),
                .COUNTER_BITS  (COUNTER_BITS),
                .CELL_ID       (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_req   (w_chain[g]),
                .o_req   (w_chain[g+1])
            );
        end
    endgenerate

    assign w_last      = w_chain[NumEntries];
    assign w_last_read = w_last.valid && (w_last.cmd == cchc_pkg::CMD_READ);
    assign w_out_free  = !r_out_vld || o_res.ready;

    // The whole chain moves together unless a finished read has nowhere to go.
    assign w_adv       = !(w_last_read && !w_out_free);
    assign i_req.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_last_read;
            r_out     <= w_last;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.live_count   = r_out.live_count;
    assign o_res.candle_open  = r_out.candle_open;
    assign o_res.candle_high  = r_out.candle_high;
    assign o_res.candle_low   = r_out.candle_low;
    assign o_res.candle_close = r_out.candle_close;

`include "char_class_histogram_candle_core_assert.svh"

    // A read held at the end of the chain must not move while it waits.
    `CCHC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_adv, $stable(w_last))
    // A read that reaches a free output register shows up as a result.
    `CCHC_ASSERT_NEXT(a_read_lands, i_clk, i_rst_n, w_last_read && w_out_free, r_out_vld)
    // A new result only ever comes from a read at the end of the chain.
    `CCHC_ASSERT_SAME(a_result_source, i_clk, i_rst_n, $rose(o_res.valid), $past(w_last_read))

endmodule

`default_nettype wire

// ===== rtl/cchc_cell.sv =====
`default_nettype none

// One entry of the histogram: its live count and its candle. The cell acts
// on the request passing through it and hands it on to the next cell.
module cchc_cell #(
    parameter int ALPHABET_SIZE = 128,
    parameter int COUNTER_BITS  = 8,
    parameter int CELL_ID       = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire cchc_pkg::t_req i_req,
    output cchc_pkg::t_req      o_req
);

    localparam int                      IdxW   = cchc_pkg::IDX_W;
    localparam logic [IdxW-1:0]         Id     = IdxW'(CELL_ID);
    localparam logic [COUNTER_BITS-1:0] CntMax = '1;

    logic [COUNTER_BITS-1:0] r_cnt, r_open, r_high, r_low, r_close;
    logic [COUNTER_BITS-1:0] n_cnt, n_open, n_high, n_low, n_close;
    cchc_pkg::t_req          r_req, n_req;
    logic                    w_match;
    logic                    w_bump;
    logic                    w_bumped_out;
    logic                    w_hit_id;

    assign w_hit_id = (IdxW'(i_req.entry_index) == Id);
    assign w_bump   = (i_req.cmd == cchc_pkg::CMD_BYTE) && w_match && (r_cnt != CntMax);

    generate
        if (CELL_ID < ALPHABET_SIZE) begin : g_char
            assign w_match      = (IdxW'(i_req.data_byte) == Id);
            assign w_bumped_out = i_req.bumped | w_bump;
        end else begin : g_class
            // A class only moves when its byte really raised a bin.
            localparam logic [3:0] ClassId = 4'(CELL_ID - ALPHABET_SIZE);
            assign w_match      = i_req.bumped &&
                                  cchc_pkg::class_member(ClassId, i_req.data_byte);
            assign w_bumped_out = i_req.bumped;
        end
    endgenerate

    always_comb begin
        n_cnt   = r_cnt;
        n_open  = r_open;
        n_high  = r_high;
        n_low   = r_low;
        n_close = r_close;
        n_req   = i_req;
        n_req.bumped = w_bumped_out;
        case (i_req.cmd)
            cchc_pkg::CMD_BYTE: begin
                if (w_bump) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cchc_pkg::CMD_EOL: begin
                n_cnt = '0;
                if (!((r_cnt == '0) && (r_close == '0))) begin
                    if (r_open == '0) begin
                        n_open = r_cnt;
                        n_high = r_cnt;
                        n_low  = r_cnt;
                    end else if (r_cnt > r_high) begin
                        n_high = r_cnt;
                    end else if (r_cnt < r_low) begin
                        n_low = r_cnt;
                    end
                    n_close = r_cnt;
                end
            end
            cchc_pkg::CMD_READ: begin
                if (w_hit_id) begin
                    n_req.live_count   = 8'(r_cnt);
                    n_req.candle_open  = 8'(r_open);
                    n_req.candle_high  = 8'(r_high);
                    n_req.candle_low   = 8'(r_low);
                    n_req.candle_close = 8'(r_close);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_open      <= '0;
            r_high      <= '0;
            r_low       <= '0;
            r_close     <= '0;
            r_req.valid <= 1'b0;
        end else if (i_adv) begin
            r_req <= n_req;
            if (i_req.valid) begin
                r_cnt   <= n_cnt;
                r_open  <= n_open;
                r_high  <= n_high;
                r_low   <= n_low;
                r_close <= n_close;
            end
        end
    end

    assign o_req = r_req;

endmodule

`default_nettype wire
